@@ src/fcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// fcrc_pkg - shared definitions for the FASTQ reverse complement unit
// Holds the line buffer sizing, line and error codes and the IUPAC
// complement lookup.
// ----------------------------------------------------------------------------
package fcrc_pkg;

    // Longest sequence or quality line that fits the line buffer
    localparam int MAX_LINE_DEFAULT = 63;

    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;

    // Position of the current line within a four-line record
    localparam logic [1:0] LINE_HEADER   = 2'd0;
    localparam logic [1:0] LINE_SEQUENCE = 2'd1;
    localparam logic [1:0] LINE_PLUS     = 2'd2;
    localparam logic [1:0] LINE_QUALITY  = 2'd3;

    // Error codes carried on the result beat
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NONBASE    = 3'd1;
    localparam logic [2:0] ERR_NOPLUS     = 3'd2;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
    localparam logic [2:0] ERR_TOOLONG    = 3'd4;

    // Uppercase IUPAC complement; zero for anything that is not a base
    function automatic logic [7:0] upper_comp(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h41:   r = 8'h54; // A -> T
            8'h42:   r = 8'h56; // B -> V
            8'h43:   r = 8'h47; // C -> G
            8'h44:   r = 8'h48; // D -> H
            8'h47:   r = 8'h43; // G -> C
            8'h48:   r = 8'h44; // H -> D
            8'h4B:   r = 8'h4D; // K -> M
            8'h4D:   r = 8'h4B; // M -> K
            8'h4E:   r = 8'h4E; // N
            8'h52:   r = 8'h59; // R -> Y
            8'h53:   r = 8'h53; // S
            8'h54:   r = 8'h41; // T -> A
            8'h56:   r = 8'h42; // V -> B
            8'h57:   r = 8'h57; // W
            8'h59:   r = 8'h52; // Y -> R
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Full complement: lowercase folds to uppercase and back
    function automatic logic [7:0] comp_base(input logic [7:0] c);
        logic [7:0] r;
        r = 8'h00;
        if (c inside {[8'h61:8'h7A]})
        begin
            r = upper_comp(c - 8'h20);
            if (r != 8'h00)
            begin
                r = r + 8'h20;
            end
        end
        else
        begin
            r = upper_comp(c);
        end
        return r;
    endfunction

endpackage

@@ src/fcrc_line_store.sv @@
// ----------------------------------------------------------------------------
// fcrc_line_store - line buffer memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module fcrc_line_store #(
    parameter int  DEPTH  = fcrc_pkg::MAX_LINE_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/fastq_reverse_complement_unit.sv @@
// ----------------------------------------------------------------------------
// fastq_reverse_complement_unit - FASTQ record reverse complementer
// Passes header and plus lines through, buffers sequence and quality lines
// and plays them back reversed (sequence also IUPAC complemented).
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                  | accepted when
//  ---------+-----+------------------------------------------+---------------------
//  s_*      | in  | tdata[7:0] data_byte, tuser end_of_input | s_tvalid & s_tready
//  m_*      | out | tdata[7:0] out_byte, tuser[2:0] error,   | m_tvalid & m_tready
//           |     | tlast last result of the input beat      |
//
//  Playback: a line end in a sequence or quality line, or an end of input
//  inside a quality line, plays the buffer back: for each stored byte a
//  read is issued on the single read port of the line buffer and the
//  registered data is then emitted, and a newline beat follows. No input
//  beat is taken during playback.
//  Reset: control state clears at once; the line buffer needs no clearing
//  pass, since only entries below the fill count are ever read.
//  Stalls: the output register holds a beat while m_tready is low; a new
//  input beat is taken while idle whenever that register is free or draining.
//
module fastq_reverse_complement_unit #(
    parameter int MAX_LINE = fcrc_pkg::MAX_LINE_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] end_of_input
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [2:0] error_code
    output logic       m_tlast
);

    localparam int ADDR_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int CNT_W  = $clog2(MAX_LINE + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_NEWLINE
    } state_t;

    state_t           state_reg,   state_next;
    logic [1:0]       line_reg,    line_next;
    logic             started_reg, started_next;
    logic [CNT_W-1:0] fill_reg,    fill_next;
    logic [CNT_W-1:0] idx_reg,     idx_next;
    logic             comp_reg,    comp_next;
    logic [2:0]       err_reg,     err_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;
    logic [2:0]       out_err_reg,   out_err_next;
    logic             out_last_reg,  out_last_next;

    logic             out_free;
    logic             accept;
    logic [7:0]       in_byte;
    logic             in_eoi;
    logic [7:0]       in_comp;
    logic [CNT_W-1:0] idx_dec;

    logic             wr_en;
    logic             rd_en;
    logic [7:0]       rd_data;
    logic [7:0]       rd_comp;

    // The output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign in_byte  = s_tdata;
    assign in_eoi   = s_tuser;
    assign in_comp  = fcrc_pkg::comp_base(in_byte);
    assign rd_comp  = fcrc_pkg::comp_base(rd_data);
    assign idx_dec  = idx_reg - CNT_W'(1);

    // Writes happen only while idle and reads only during playback, so the
    // state machine itself keeps the two ports off the same entry.
    fcrc_line_store #(
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (in_byte),
        .rd_en   (rd_en),
        .rd_addr (idx_dec[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        line_next      = line_reg;
        started_next   = started_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        comp_next      = comp_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // Once an error is latched, take every beat and drop it
                if (accept && (err_reg == fcrc_pkg::ERR_NONE))
                begin
                    if (in_eoi)
                    begin
                        if ((line_reg == fcrc_pkg::LINE_HEADER) && !started_reg)
                        begin
                            // clean end at a record boundary: nothing to say
                        end
                        else if ((line_reg == fcrc_pkg::LINE_QUALITY) && started_reg)
                        begin
                            // close an unterminated quality line
                            idx_next     = fill_reg;
                            fill_next    = '0;
                            started_next = 1'b0;
                            comp_next    = 1'b0;
                            line_next    = fcrc_pkg::LINE_HEADER;
                            state_next   = ST_READ;
                        end
                        else
                        begin
                            err_next       = fcrc_pkg::ERR_INCOMPLETE;
                            out_valid_next = 1'b1;
                            out_byte_next  = 8'h00;
                            out_err_next   = fcrc_pkg::ERR_INCOMPLETE;
                            out_last_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        case (line_reg)
                            fcrc_pkg::LINE_HEADER,
                            fcrc_pkg::LINE_PLUS:
                            begin
                                if ((line_reg == fcrc_pkg::LINE_PLUS) && !started_reg &&
                                    (in_byte != fcrc_pkg::CHAR_PLUS))
                                begin
                                    err_next       = fcrc_pkg::ERR_NOPLUS;
                                    out_valid_next = 1'b1;
                                    out_byte_next  = 8'h00;
                                    out_err_next   = fcrc_pkg::ERR_NOPLUS;
                                    out_last_next  = 1'b1;
                                end
                                else
                                begin
                                    // pass the byte straight through
                                    out_valid_next = 1'b1;
                                    out_byte_next  = in_byte;
                                    out_err_next   = fcrc_pkg::ERR_NONE;
                                    out_last_next  = 1'b1;
                                    if (in_byte == fcrc_pkg::CHAR_NL)
                                    begin
                                        started_next = 1'b0;
                                        line_next    = (line_reg == fcrc_pkg::LINE_HEADER) ?
                                                       fcrc_pkg::LINE_SEQUENCE :
                                                       fcrc_pkg::LINE_QUALITY;
                                    end
                                    else
                                    begin
                                        started_next = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                // sequence or quality line
                                if (in_byte == fcrc_pkg::CHAR_NL)
                                begin
                                    idx_next     = fill_reg;
                                    fill_next    = '0;
                                    started_next = 1'b0;
                                    comp_next    = (line_reg == fcrc_pkg::LINE_SEQUENCE);
                                    line_next    = (line_reg == fcrc_pkg::LINE_SEQUENCE) ?
                                                   fcrc_pkg::LINE_PLUS :
                                                   fcrc_pkg::LINE_HEADER;
                                    state_next   = ST_READ;
                                end
                                else if ((line_reg == fcrc_pkg::LINE_SEQUENCE) &&
                                         (in_comp == 8'h00))
                                begin
                                    err_next       = fcrc_pkg::ERR_NONBASE;
                                    out_valid_next = 1'b1;
                                    out_byte_next  = 8'h00;
                                    out_err_next   = fcrc_pkg::ERR_NONBASE;
                                    out_last_next  = 1'b1;
                                end
                                else if (fill_reg >= CNT_W'(MAX_LINE))
                                begin
                                    err_next       = fcrc_pkg::ERR_TOOLONG;
                                    out_valid_next = 1'b1;
                                    out_byte_next  = 8'h00;
                                    out_err_next   = fcrc_pkg::ERR_TOOLONG;
                                    out_last_next  = 1'b1;
                                end
                                else
                                begin
                                    wr_en        = 1'b1;
                                    fill_next    = fill_reg + CNT_W'(1);
                                    started_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_READ:
            begin
                // fetch the next byte from the top of the buffer downwards
                if (idx_reg == '0)
                begin
                    state_next = ST_NEWLINE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    idx_next   = idx_dec;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = comp_reg ? rd_comp : rd_data;
                    out_err_next   = fcrc_pkg::ERR_NONE;
                    out_last_next  = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_NEWLINE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = fcrc_pkg::CHAR_NL;
                    out_err_next   = fcrc_pkg::ERR_NONE;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            line_reg      <= fcrc_pkg::LINE_HEADER;
            started_reg   <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            comp_reg      <= 1'b0;
            err_reg       <= fcrc_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_err_reg   <= fcrc_pkg::ERR_NONE;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_reg      <= line_next;
            started_reg   <= started_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            comp_reg      <= comp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_err_reg   <= out_err_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/fcrc_checker.sv @@
// ----------------------------------------------------------------------------
// fcrc_checker - port-level checks for the reverse complement unit
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fcrc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // An error beat carries a zero byte and closes its group
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != fcrc_pkg::ERR_NONE) |-> (m_tdata == 8'h00) && m_tlast)
        else $error("malformed error beat");

    // Only defined error codes appear
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == fcrc_pkg::ERR_NONE) ||
                     (m_tuser == fcrc_pkg::ERR_NONBASE) ||
                     (m_tuser == fcrc_pkg::ERR_NOPLUS) ||
                     (m_tuser == fcrc_pkg::ERR_INCOMPLETE) ||
                     (m_tuser == fcrc_pkg::ERR_TOOLONG))
        else $error("undefined error code");

    // After an error is delivered the output stays silent
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser != fcrc_pkg::ERR_NONE) |=> !m_tvalid)
        else $error("output after latched error");

    // Input is never taken while a beat sits stalled with no room behind it
    a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken with output register full");

endmodule

bind fastq_reverse_complement_unit fcrc_checker u_fcrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
